>>> rtl/bpa_pkg.sv
// ============================================================================
// bpa_pkg: shared types and constants of the bitmap page allocator
// Request and result payload types, status codes and register indexes.
// ============================================================================
package bpa_pkg;

    typedef struct packed {
        logic       pool;
        logic [6:0] page_count;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] virt_addr;
        logic [31:0] phys_addr;
        logic        last;
    } t_res;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_VIRT = 2'd1;
    localparam logic [1:0] ST_NO_PHYS = 2'd2;
    localparam logic [1:0] ST_BAD_CNT = 2'd3;

    localparam logic [2:0] REG_KPHYS = 3'd0;
    localparam logic [2:0] REG_UPHYS = 3'd1;
    localparam logic [2:0] REG_KPAGES = 3'd2;
    localparam logic [2:0] REG_UPAGES = 3'd3;
    localparam logic [2:0] REG_KVIRT = 3'd4;

endpackage

>>> rtl/bitmap_page_allocator.sv
// ============================================================================
// bitmap_page_allocator: first-fit kernel page request engine
// Keeps virtual-page and frame bitmaps in word memories and serves requests.
// ============================================================================
//
//  channel   direction  handshake             payload
//  request   in         i_start & !o_busy     i_req  (bpa_pkg::t_req)
//  result    out        o_res_valid, 1 cycle  o_res  (bpa_pkg::t_res)
//  config    in         APB write, no wait    pwdata at paddr
//
// One bitmap word is read through a registered memory port (S_VRD, S_VWT) and
// is then examined one bit per cycle within the fetched word in the virtual run
// search (S_VCHK); marking reads and writes back each page's word (S_MRD, S_MWR).
// Each frame search restarts at bit 0 with the same word fetch and bit examination
// (S_FRD, S_FWT, S_FCHK), and S_FWR marks the frame. A bad count or a user request
// gives its result through S_OUT. After reset a clearing pass over all MAP_WORDS
// words of both bitmaps runs with o_busy high. Results cannot be stalled; each is shown for one cycle.
module bitmap_page_allocator #(
    parameter int POOL_PAGES  = 16384,
    parameter int MAX_REQUEST = 64,
    parameter int PAGE_BYTES  = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  bpa_pkg::t_req       i_req,
    output logic                o_busy,
    output logic                o_res_valid,
    output bpa_pkg::t_res       o_res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam int MAP_WORDS = (POOL_PAGES + 31) / 32;
    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IW = $clog2(POOL_PAGES + 1);
    localparam int SH = $clog2(PAGE_BYTES);

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_VRD = 4'd2, S_VWT = 4'd3,
                           S_VCHK = 4'd4, S_MRD = 4'd5, S_MWR = 4'd6, S_FRD = 4'd7,
                           S_FWT = 4'd8, S_FCHK = 4'd9, S_FWR = 4'd10, S_OUT = 4'd11;

    logic [31:0] vmem [MAP_WORDS];
    logic [31:0] fmem [MAP_WORDS];

    logic [3:0]    r_state, n_state;
    logic [31:0]   r_kphys, r_uphys, r_kvirt;
    logic [14:0]   r_kpages, r_upages;
    logic [IW-1:0] r_idx, n_idx;       // bit index being examined
    logic [IW-1:0] r_run, n_run;
    logic [IW-1:0] r_vstart, n_vstart;
    logic [6:0]    r_cnt, n_cnt;
    logic [6:0]    r_pg, n_pg;
    logic [31:0]   r_rd;               // registered read data
    logic [AW-1:0] r_raddr;
    logic          r_vsel;
    logic [AW-1:0] n_raddr;
    logic          n_vsel, n_re;
    logic          n_vwe, n_fwe;
    logic [AW-1:0] n_waddr;
    logic [31:0]   n_wdata;
    logic          r_ov, n_ov;
    bpa_pkg::t_res r_res, n_res;
    logic [AW-1:0] r_clr;
    logic [31:0]   r_word, n_word;     // word under modification

    logic [IW-1:0] w_limit;
    logic [14:0]   w_kp8;
    logic          w_bit;
    logic [IW-1:0] w_fidx;

    assign w_kp8   = {r_kpages[14:3], 3'b000};
    assign w_limit = ({17'd0, w_kp8} > 32'(POOL_PAGES)) ? IW'(POOL_PAGES)
                                                         : IW'(w_kp8);
    assign w_bit   = r_rd[r_idx[4:0]];
    assign w_fidx  = r_idx;

    always_ff @(posedge i_clk) begin
        if (n_re) begin
            r_rd <= n_vsel ? vmem[n_raddr] : fmem[n_raddr];
        end
        if (n_vwe) begin
            vmem[n_waddr] <= n_wdata;
        end
        if (n_fwe) begin
            fmem[n_waddr] <= n_wdata;
        end
    end

    always_comb begin
        n_state = r_state; n_idx = r_idx; n_run = r_run; n_vstart = r_vstart;
        n_cnt = r_cnt; n_pg = r_pg; n_ov = 1'b0; n_res = r_res; n_word = r_word;
        n_re = 1'b0; n_vsel = r_vsel; n_raddr = r_raddr;
        n_vwe = 1'b0; n_fwe = 1'b0; n_waddr = r_clr; n_wdata = '0;
        case (r_state)
            S_CLR: begin
                n_vwe = 1'b1; n_fwe = 1'b1;
                if (r_clr == AW'(MAP_WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cnt = i_req.page_count; n_idx = '0; n_run = '0; n_pg = '0;
                    n_res = '{status: bpa_pkg::ST_BAD_CNT, virt_addr: '0,
                              phys_addr: '0, last: 1'b1};
                    if (i_req.page_count == 7'd0 || 32'(i_req.page_count) > MAX_REQUEST) begin
                        n_state = S_OUT;
                    end else if (i_req.pool) begin
                        n_res.status = bpa_pkg::ST_NO_VIRT; n_state = S_OUT;
                    end else begin
                        n_state = S_VRD;
                    end
                end
            end
            S_VRD: begin
                if (r_idx >= w_limit) begin
                    n_res = '{status: bpa_pkg::ST_NO_VIRT, virt_addr: '0,
                              phys_addr: '0, last: 1'b1};
                    n_state = S_OUT;
                end else begin
                    n_re = 1'b1; n_vsel = 1'b1; n_raddr = AW'(r_idx >> 5);
                    n_state = S_VWT;
                end
            end
            S_VWT: n_state = S_VCHK;
            S_VCHK: begin
                // One bit per cycle within the fetched word.
                if (w_bit) n_run = '0;
                else n_run = r_run + 1'b1;
                n_idx = r_idx + 1'b1;
                if (!w_bit && (r_run + 1'b1) == IW'(r_cnt)) begin
                    n_vstart = r_idx + 1'b1 - IW'(r_cnt);
                    n_idx = r_idx + 1'b1 - IW'(r_cnt);
                    n_pg = '0; n_state = S_MRD;
                end else if (r_idx + 1'b1 >= w_limit) begin
                    n_res = '{status: bpa_pkg::ST_NO_VIRT, virt_addr: '0,
                              phys_addr: '0, last: 1'b1};
                    n_state = S_OUT;
                end else if (r_idx[4:0] == 5'd31) begin
                    n_state = S_VRD;
                end
            end
            S_MRD: begin
                n_re = 1'b1; n_vsel = 1'b1; n_raddr = AW'(r_idx >> 5);
                n_state = S_MWR;
            end
            S_MWR: begin
                // Read data arrives now; write one bit back.
                n_word = r_rd | (32'd1 << r_idx[4:0]);
                n_vwe = 1'b1; n_waddr = AW'(r_idx >> 5); n_wdata = n_word;
                n_pg = r_pg + 1'b1; n_idx = r_idx + 1'b1;
                if (r_pg + 1'b1 == r_cnt) begin
                    n_pg = '0; n_idx = '0; n_state = S_FRD;
                end else begin
                    n_state = S_MRD;
                end
            end
            S_FRD: begin
                if (r_idx >= w_limit) begin
                    n_res = '{status: bpa_pkg::ST_NO_PHYS, virt_addr: '0,
                              phys_addr: '0, last: 1'b1};
                    n_state = S_OUT;
                end else begin
                    n_re = 1'b1; n_vsel = 1'b0; n_raddr = AW'(r_idx >> 5);
                    n_state = S_FWT;
                end
            end
            S_FWT: n_state = S_FCHK;
            S_FCHK: begin
                if (!w_bit) begin
                    n_state = S_FWR;
                end else begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx + 1'b1 >= w_limit) begin
                        n_res = '{status: bpa_pkg::ST_NO_PHYS, virt_addr: '0,
                                  phys_addr: '0, last: 1'b1};
                        n_state = S_OUT;
                    end else if (r_idx[4:0] == 5'd31) begin
                        n_state = S_FRD;
                    end
                end
            end
            S_FWR: begin
                n_fwe = 1'b1; n_waddr = AW'(r_idx >> 5);
                n_wdata = r_rd | (32'd1 << r_idx[4:0]);
                n_res.status = bpa_pkg::ST_OK;
                n_res.virt_addr = r_kvirt + (32'(r_vstart + IW'(r_pg)) << SH);
                n_res.phys_addr = r_kphys + (32'(w_fidx) << SH);
                n_res.last = (r_pg + 1'b1 == r_cnt);
                n_ov = 1'b1;
                n_pg = r_pg + 1'b1; n_idx = '0;
                n_state = (r_pg + 1'b1 == r_cnt) ? S_IDLE : S_FRD;
            end
            S_OUT: begin
                n_ov = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_clr <= '0; r_ov <= 1'b0;
            r_kphys <= 32'd3145728; r_uphys <= 32'd17825792;
            r_kpages <= 15'd3584; r_upages <= 15'd3584; r_kvirt <= 32'hC010_0000;
        end else begin
            r_state <= n_state; r_ov <= n_ov;
            if (r_state == S_CLR) r_clr <= r_clr + 1'b1;
            if (psel && penable && pwrite) begin
                case (paddr[4:2])
                    bpa_pkg::REG_KPHYS:  r_kphys <= pwdata;
                    bpa_pkg::REG_UPHYS:  r_uphys <= pwdata;
                    bpa_pkg::REG_KPAGES: r_kpages <= pwdata[14:0];
                    bpa_pkg::REG_UPAGES: r_upages <= pwdata[14:0];
                    bpa_pkg::REG_KVIRT:  r_kvirt <= pwdata;
                    default: ;
                endcase
            end
        end
        r_idx <= n_idx; r_run <= n_run; r_vstart <= n_vstart; r_cnt <= n_cnt;
        r_pg <= n_pg; r_res <= n_res; r_word <= n_word;
        r_raddr <= n_raddr; r_vsel <= n_vsel;
    end

    always_comb begin
        case (paddr[4:2])
            bpa_pkg::REG_KPHYS:  prdata = r_kphys;
            bpa_pkg::REG_UPHYS:  prdata = r_uphys;
            bpa_pkg::REG_KPAGES: prdata = {17'd0, r_kpages};
            bpa_pkg::REG_UPAGES: prdata = {17'd0, r_upages};
            bpa_pkg::REG_KVIRT:  prdata = r_kvirt;
            default:             prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_ov;
    assign o_res       = r_res;

endmodule
